FILE: rtl/tbcm_pkg.sv
// Package for the tape block cycle modulator.
// Holds the symbol codes, register indexes, reset values and the job and config types.
// No dependencies.
`default_nettype none

package tbcm_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 16;
  localparam int unsigned SumW   = 16;
  localparam int unsigned SyncW  = 8;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [1:0] {
    KIND_SILENCE = 2'd0,
    KIND_LEADER  = 2'd1,
    KIND_LONG    = 2'd2,
    KIND_SHORT   = 2'd3
  } sym_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LEADER_CYCLES = 2'd0,
    REG_FIRST_SYNC    = 2'd1,
    REG_LATER_SYNC    = 2'd2,
    REG_GAP_SAMPLES   = 2'd3
  } cfg_idx_e;

  localparam logic [CountW-1:0] LeaderReset    = 16'd4000;
  localparam logic [SyncW-1:0]  FirstSyncReset = 8'd40;
  localparam logic [SyncW-1:0]  LaterSyncReset = 8'd20;
  localparam logic [CountW-1:0] GapReset       = 16'd4800;

  // Two long cycles close the sync pattern.
  localparam logic [CountW-1:0] SyncTailCount = 16'd2;

  typedef struct packed {
    logic [CountW-1:0] leader_cycles;
    logic [SyncW-1:0]  first_sync_count;
    logic [SyncW-1:0]  later_sync_count;
    logic [CountW-1:0] gap_samples;
  } cfg_t;

  // One classified byte on its way to the symbol sequencer.
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             block_start;
    logic             first_block;
    logic             block_end;
    logic [SumW-1:0]  block_sum;
  } job_t;

endpackage

`default_nettype wire

FILE: rtl/tbcm_in_if.sv
// Input channel interface: tape block bytes with their block flags.
// Plain valid/ready handshake; no dependencies.
`default_nettype none

interface tbcm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_start;
  logic       first_block;
  logic       block_end;

  modport source (output valid, output data_byte, output block_start,
                  output first_block, output block_end, input ready);
  modport sink (input valid, input data_byte, input block_start,
                input first_block, input block_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/tbcm_out_if.sv
// Output channel interface: run-length cycle symbols.
// Plain valid/ready handshake; no dependencies.
`default_nettype none

interface tbcm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  symbol_kind;
  logic [15:0] repeat_count;
  logic        last_symbol;

  modport source (output valid, output symbol_kind, output repeat_count,
                  output last_symbol, input ready);
  modport sink (input valid, input symbol_kind, input repeat_count,
                input last_symbol, output ready);
endinterface

`default_nettype wire

FILE: rtl/tbcm_front.sv
// Front end: accepts bytes, keeps the running block sum and builds jobs.
// Depends on tbcm_pkg and tbcm_in_if.
`default_nettype none

module tbcm_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  tbcm_in_if.sink              in_ch,
  output logic                 push_valid_o,
  input  wire                  push_ready_i,
  output tbcm_pkg::job_t       push_job_o
);
  import tbcm_pkg::*;

  logic [SumW-1:0] sum_q, sum_d;
  logic [SumW-1:0] sum_base;
  logic            accept;

  assign in_ch.ready  = push_ready_i;
  assign push_valid_o = in_ch.valid;
  assign accept       = in_ch.valid && push_ready_i;

  // A block start restarts the sum at this byte.
  assign sum_base = in_ch.block_start ? '0 : sum_q;
  assign sum_d    = sum_base + {{(SumW-ByteW){1'b0}}, in_ch.data_byte};

  always_comb begin
    push_job_o.data_byte   = in_ch.data_byte;
    push_job_o.block_start = in_ch.block_start;
    push_job_o.first_block = in_ch.first_block;
    push_job_o.block_end   = in_ch.block_end;
    push_job_o.block_sum   = sum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (accept) begin
      sum_q <= in_ch.block_end ? '0 : sum_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tbcm_queue.sv
// Two-entry job queue between the front end and the symbol sequencer.
// Depends on tbcm_pkg.
`default_nettype none

module tbcm_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_valid_i,
  output logic                 push_ready_o,
  input  tbcm_pkg::job_t       push_job_i,
  output logic                 pop_valid_o,
  input  wire                  pop_ready_i,
  output tbcm_pkg::job_t       pop_job_o
);
  import tbcm_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tbcm_back.sv
// Back end: walks the job at the queue head and emits one symbol per cycle while the output is ready.
// Depends on tbcm_pkg and tbcm_out_if.
`default_nettype none

module tbcm_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  tbcm_pkg::cfg_t       cfg_i,
  input  wire                  job_valid_i,
  output logic                 job_ready_o,
  input  tbcm_pkg::job_t       job_i,
  tbcm_out_if.source           out_ch
);
  import tbcm_pkg::*;

  typedef enum logic [3:0] {
    PH_BEGIN,
    PH_GAP_HEAD,
    PH_LEADER,
    PH_SYNC_LONG,
    PH_SYNC_SHORT,
    PH_SYNC_TAIL,
    PH_DATA,
    PH_SUM_HI,
    PH_SUM_LO,
    PH_GAP_TAIL
  } phase_e;

  phase_e            phase_q, cur_ph, next_ph;
  logic [3:0]        bit_q;
  logic              out_valid_q;
  sym_kind_e         kind_q, kind;
  logic [CountW-1:0] count_q, count;
  logic              last_q, last;
  logic [CountW-1:0] sync_cnt;
  logic [ByteW-1:0]  cur_byte;
  logic              stop_bit, byte_ph, load;

  assign sync_cnt = {{(CountW-SyncW){1'b0}},
                     job_i.first_block ? cfg_i.first_sync_count : cfg_i.later_sync_count};

  // Resolve the opening phase of a fresh job.
  always_comb begin
    cur_ph = phase_q;
    if (phase_q == PH_BEGIN) begin
      if (job_i.block_start && job_i.first_block) cur_ph = PH_GAP_HEAD;
      else if (job_i.block_start)                 cur_ph = PH_LEADER;
      else                                        cur_ph = PH_DATA;
    end
  end

  assign byte_ph  = (cur_ph == PH_DATA) || (cur_ph == PH_SUM_HI) || (cur_ph == PH_SUM_LO);
  assign stop_bit = (bit_q == 4'd8);

  always_comb begin
    case (cur_ph)
      PH_SUM_HI: cur_byte = job_i.block_sum[SumW-1:ByteW];
      PH_SUM_LO: cur_byte = job_i.block_sum[ByteW-1:0];
      default:   cur_byte = job_i.data_byte;
    endcase
  end

  always_comb begin
    kind    = KIND_LONG;
    count   = 16'd1;
    next_ph = cur_ph;
    last    = 1'b0;
    case (cur_ph)
      PH_GAP_HEAD: begin
        kind    = KIND_SILENCE;
        count   = cfg_i.gap_samples;
        next_ph = PH_LEADER;
      end
      PH_LEADER: begin
        kind    = KIND_LEADER;
        count   = cfg_i.leader_cycles;
        next_ph = PH_SYNC_LONG;
      end
      PH_SYNC_LONG: begin
        count   = sync_cnt;
        next_ph = PH_SYNC_SHORT;
      end
      PH_SYNC_SHORT: begin
        kind    = KIND_SHORT;
        count   = sync_cnt;
        next_ph = PH_SYNC_TAIL;
      end
      PH_SYNC_TAIL: begin
        count   = SyncTailCount;
        next_ph = PH_DATA;
      end
      PH_DATA, PH_SUM_HI, PH_SUM_LO: begin
        // MSB first; bit index 8 is the long stop cycle.
        if (!stop_bit && !cur_byte[~bit_q[2:0]]) kind = KIND_SHORT;
        if (stop_bit) begin
          case (cur_ph)
            PH_DATA: begin
              next_ph = PH_SUM_HI;
              last    = !job_i.block_end;
            end
            PH_SUM_HI: next_ph = PH_SUM_LO;
            default:   next_ph = PH_GAP_TAIL;
          endcase
        end
      end
      PH_GAP_TAIL: begin
        kind  = KIND_SILENCE;
        count = cfg_i.gap_samples;
        last  = 1'b1;
      end
      default: begin
        kind = KIND_LONG;
      end
    endcase
  end

  assign load        = job_valid_i && (!out_valid_q || out_ch.ready);
  assign job_ready_o = load && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_BEGIN;
      bit_q       <= 4'd0;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_SILENCE;
      count_q     <= '0;
      last_q      <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        kind_q      <= kind;
        count_q     <= count;
        last_q      <= last;
        if (last) begin
          phase_q <= PH_BEGIN;
          bit_q   <= 4'd0;
        end else if (byte_ph && !stop_bit) begin
          phase_q <= cur_ph;
          bit_q   <= bit_q + 4'd1;
        end else begin
          phase_q <= next_ph;
          bit_q   <= 4'd0;
        end
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.symbol_kind  = kind_q;
  assign out_ch.repeat_count = count_q;
  assign out_ch.last_symbol  = last_q;

  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_q <= 4'd8)
    else $error("bit counter out of range");

  a_pop_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_ready_o |=> (phase_q == PH_BEGIN) && (bit_q == 4'd0))
    else $error("sequencer did not restart after job pop");

  a_sum_needs_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q == PH_SUM_HI) || (phase_q == PH_SUM_LO) || (phase_q == PH_GAP_TAIL))
      |-> (job_valid_i && job_i.block_end))
    else $error("checksum phase without block end");

  a_preamble_needs_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q == PH_LEADER) || (phase_q == PH_SYNC_LONG) || (phase_q == PH_SYNC_TAIL))
      |-> (job_valid_i && job_i.block_start))
    else $error("preamble phase without block start");

endmodule

`default_nettype wire

FILE: rtl/tape_block_cycle_modulator.sv
// Top level of the tape block cycle modulator: config registers, front end,
// job queue and symbol sequencer. Depends on tbcm_pkg, tbcm_in_if, tbcm_out_if,
// tbcm_front, tbcm_queue and tbcm_back.
//
//   channel  | dir | handshake      | payload
//   ---------+-----+----------------+---------------------------------------------
//   in_ch    | in  | valid/ready    | data_byte, block_start, first_block, block_end
//   out_ch   | out | valid/ready    | symbol_kind, repeat_count, last_symbol
//   cfg      | in  | cfg_we_i only  | cfg_idx_i, cfg_wdata_i
//
// One symbol leaves per clock when out_ch.ready is high: a plain byte yields
// nine symbols, a block-opening byte four or five more, a block-closing byte
// nineteen more. The symbol sequencer in tbcm_back sets these counts.
// A two-entry queue lets the front end take the next byte while symbols of
// the current one are still draining; a stalled output holds its register.
// Reset loads the register defaults and clears the block sum and queue.
`default_nettype none

module tape_block_cycle_modulator (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [tbcm_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire  [tbcm_pkg::CountW-1:0]      cfg_wdata_i,
  tbcm_in_if.sink                          in_ch,
  tbcm_out_if.source                       out_ch
);
  import tbcm_pkg::*;

  cfg_t cfg_q;
  logic push_valid, push_ready, pop_valid, pop_ready;
  job_t push_job, pop_job;

  // Register file; write only while no byte or symbol is in flight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_cycles    <= LeaderReset;
      cfg_q.first_sync_count <= FirstSyncReset;
      cfg_q.later_sync_count <= LaterSyncReset;
      cfg_q.gap_samples      <= GapReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_LEADER_CYCLES: cfg_q.leader_cycles    <= cfg_wdata_i;
        REG_FIRST_SYNC:    cfg_q.first_sync_count <= cfg_wdata_i[SyncW-1:0];
        REG_LATER_SYNC:    cfg_q.later_sync_count <= cfg_wdata_i[SyncW-1:0];
        REG_GAP_SAMPLES:   cfg_q.gap_samples      <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Classify bytes and track the block sum.
  tbcm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  // Decouple intake from symbol emission.
  tbcm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  // Expand each job into run-length symbols.
  tbcm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .job_i       (pop_job),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

FILE: bench/tbcm_cycle_check.sv
// Scoreboard for the tape block cycle modulator: follows register writes and byte transfers,
// predicts the run-length cycle symbols and compares every symbol transfer in order.
// Depends on tbcm_pkg, tbcm_in_if and tbcm_out_if.
module tbcm_cycle_check (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tbcm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tbcm_pkg::CountW-1:0]  cfg_wdata_i,
  tbcm_in_if                           in_ch,
  tbcm_out_if                          out_ch,
  output int                           err_count_o,
  output int                           exp_left_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import tbcm_pkg::*;

  typedef struct {
    sym_kind_e         kind;
    logic [CountW-1:0] count;
    logic              last;
  } cycle_sym_t;

  cycle_sym_t        tape_syms_q[$];
  cfg_t              tape_cfg;
  logic [SumW-1:0]   running_sum;

  function automatic void add_sym(sym_kind_e kind, logic [CountW-1:0] count);
    cycle_sym_t s;
    s.kind  = kind;
    s.count = count;
    s.last  = 1'b0;
    tape_syms_q.insert(tape_syms_q.size(), s);
  endfunction

  // Eight bit cycles MSB first, then the long stop cycle.
  function automatic void add_byte_cycles(logic [ByteW-1:0] value);
    for (int b = ByteW - 1; b >= 0; b--) begin
      add_sym(value[b] ? KIND_LONG : KIND_SHORT, CountW'(1));
    end
    add_sym(KIND_LONG, CountW'(1));
  endfunction

  function automatic void encode_tape_byte(logic [ByteW-1:0] data, logic opens,
                                           logic is_first, logic closes);
    logic [SyncW-1:0] sync;
    if (opens) begin
      sync = is_first ? tape_cfg.first_sync_count : tape_cfg.later_sync_count;
      if (is_first) add_sym(KIND_SILENCE, tape_cfg.gap_samples);
      add_sym(KIND_LEADER, tape_cfg.leader_cycles);
      add_sym(KIND_LONG, CountW'(sync));
      add_sym(KIND_SHORT, CountW'(sync));
      add_sym(KIND_LONG, SyncTailCount);
      running_sum = '0;
    end
    add_byte_cycles(data);
    running_sum = running_sum + SumW'(data);
    if (closes) begin
      add_byte_cycles(running_sum[15:8]);
      add_byte_cycles(running_sum[7:0]);
      add_sym(KIND_SILENCE, tape_cfg.gap_samples);
      running_sum = '0;
    end
    tape_syms_q[tape_syms_q.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cycle_sym_t want;
    if (!rst_ni) begin
      tape_cfg.leader_cycles    <= LeaderReset;
      tape_cfg.first_sync_count <= FirstSyncReset;
      tape_cfg.later_sync_count <= LaterSyncReset;
      tape_cfg.gap_samples      <= GapReset;
      running_sum  = '0;
      tape_syms_q.delete();
      err_count_o <= 0;
      exp_left_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          REG_LEADER_CYCLES: tape_cfg.leader_cycles    <= cfg_wdata_i;
          REG_FIRST_SYNC:    tape_cfg.first_sync_count <= cfg_wdata_i[SyncW-1:0];
          REG_LATER_SYNC:    tape_cfg.later_sync_count <= cfg_wdata_i[SyncW-1:0];
          REG_GAP_SAMPLES:   tape_cfg.gap_samples      <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        encode_tape_byte(in_ch.data_byte, in_ch.block_start, in_ch.first_block,
                         in_ch.block_end);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (tape_syms_q.size() == 0) begin
          $display("%0t: unexpected symbol, expected none, got kind %0d count %0d last %0b",
                   $time, out_ch.symbol_kind, out_ch.repeat_count, out_ch.last_symbol);
          err_count_o <= err_count_o + 1;
        end else begin
          want = tape_syms_q.pop_front();
          if (out_ch.symbol_kind !== want.kind || out_ch.repeat_count !== want.count ||
              out_ch.last_symbol !== want.last) begin
            $display("%0t: symbol mismatch, expected kind %0d count %0d last %0b,",
                     $time, want.kind, want.count, want.last,
                     " got kind %0d count %0d last %0b",
                     out_ch.symbol_kind, out_ch.repeat_count, out_ch.last_symbol);
            err_count_o <= err_count_o + 1;
          end
        end
      end
      exp_left_o <= tape_syms_q.size();
    end
  end

endmodule

FILE: bench/tb_tape_block_cycle_modulator.sv
// Top of the tape block cycle modulator bench: clock, reset, register writes, byte stimulus
// and symbol back-pressure; checking lives in tbcm_cycle_check. Depends on tbcm_pkg,
// tbcm_in_if, tbcm_out_if, tape_block_cycle_modulator and tbcm_cycle_check.
module tb_tape_block_cycle_modulator;
  timeunit 1ns;
  timeprecision 1ps;
  import tbcm_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CountW-1:0]  cfg_wdata;
  int                 err_count;
  int                 exp_left;

  // burst: both sides drop their random idle cycles.
  // squeeze: ask the symbol side for one long hold-off.
  bit                 burst;
  bit                 squeeze;

  tbcm_in_if  byte_ch ();
  tbcm_out_if sym_ch ();

  tape_block_cycle_modulator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_ch       (byte_ch),
    .out_ch      (sym_ch)
  );

  tbcm_cycle_check u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_ch       (byte_ch),
    .out_ch      (sym_ch),
    .err_count_o (err_count),
    .exp_left_o  (exp_left)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop: a run that is still going at this time fails.
  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  // Write one register; the write lands at the next rising edge.
  task automatic set_reg(input cfg_idx_e idx, input logic [CountW-1:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Offer one byte after a random idle, then hold it until the transfer.
  // Valid stays high when no idle is drawn, so back-to-back bytes need no gap.
  task automatic offer_byte(input logic [7:0] data, input logic opens,
                            input logic is_first, input logic closes);
    int idle;
    idle = burst ? 0 : $urandom_range(3);
    @(negedge clk_i);
    if (idle != 0) begin
      byte_ch.valid <= 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    byte_ch.valid       <= 1'b1;
    byte_ch.data_byte   <= data;
    byte_ch.block_start <= opens;
    byte_ch.first_block <= is_first;
    byte_ch.block_end   <= closes;
    do @(posedge clk_i); while (!byte_ch.ready);
  endtask

  // One well-formed block with random content; the first flag on later bytes is
  // random since the block ignores it there.
  task automatic send_block(input int len, input logic is_first);
    for (int i = 0; i < len; i++) begin
      offer_byte(8'($urandom), i == 0, (i == 0) ? is_first : 1'($urandom),
                 i == len - 1);
    end
  endtask

  // Drop valid so the last byte is not taken again, then wait until every
  // predicted symbol is out; a short margin covers any work in flight.
  task automatic drain();
    @(negedge clk_i);
    byte_ch.valid <= 1'b0;
    while (exp_left != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Symbol side: random stall per symbol, one long hold-off on request so the
  // job queue fills and the byte side stalls.
  initial begin
    int stall;
    sym_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (squeeze) begin
        squeeze = 1'b0;
        stall = 200;
      end else begin
        stall = burst ? 0 : $urandom_range(3);
      end
      @(negedge clk_i);
      if (stall != 0) begin
        sym_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      sym_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!sym_ch.valid);
    end
  end

  initial begin
    int sent;
    int len;
    byte_ch.valid       <= 1'b0;
    byte_ch.data_byte   <= '0;
    byte_ch.block_start <= 1'b0;
    byte_ch.first_block <= 1'b0;
    byte_ch.block_end   <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= REG_LEADER_CYCLES;
    cfg_wdata <= '0;
    burst   = 1'b0;
    squeeze = 1'b0;
    rst_ni  <= 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset register values.
    offer_byte(8'h00, 1'b1, 1'b1, 1'b0);  // first block, with leading silence
    offer_byte(8'hFF, 1'b0, 1'b0, 1'b0);
    offer_byte(8'hA5, 1'b0, 1'b0, 1'b1);  // close: sum bytes and trailing gap
    offer_byte(8'h5A, 1'b1, 1'b0, 1'b0);  // later block, short sync run
    offer_byte(8'h3C, 1'b0, 1'b1, 1'b0);  // first flag without start is ignored
    offer_byte(8'h81, 1'b1, 1'b0, 1'b0);  // restart inside an open block
    offer_byte(8'h7E, 1'b0, 1'b0, 1'b1);
    offer_byte(8'hC3, 1'b0, 1'b0, 1'b0);  // bytes outside any block still sum
    offer_byte(8'h12, 1'b0, 1'b0, 1'b1);
    offer_byte(8'hFF, 1'b1, 1'b1, 1'b1);  // one-byte block
    drain();

    // Zero counts still yield their symbols.
    set_reg(REG_LEADER_CYCLES, 16'd0);
    set_reg(REG_FIRST_SYNC, 16'd0);
    set_reg(REG_LATER_SYNC, 16'd0);
    set_reg(REG_GAP_SAMPLES, 16'd0);
    offer_byte(8'h80, 1'b1, 1'b1, 1'b1);
    offer_byte(8'h01, 1'b1, 1'b0, 1'b1);
    drain();

    // Largest counts.
    set_reg(REG_LEADER_CYCLES, 16'hFFFF);
    set_reg(REG_FIRST_SYNC, 16'h00FF);
    set_reg(REG_LATER_SYNC, 16'h00FF);
    set_reg(REG_GAP_SAMPLES, 16'hFFFF);
    offer_byte(8'hAA, 1'b1, 1'b1, 1'b0);
    offer_byte(8'h55, 1'b0, 1'b0, 1'b1);
    offer_byte(8'hF0, 1'b1, 1'b0, 1'b0);
    offer_byte(8'h0F, 1'b0, 1'b0, 1'b1);
    drain();

    // Random part: mostly whole blocks, some stray bytes with random flags.
    for (int ph = 0; ph < 3; ph++) begin
      set_reg(REG_LEADER_CYCLES, 16'($urandom));
      set_reg(REG_FIRST_SYNC, 16'($urandom_range(255)));
      set_reg(REG_LATER_SYNC, 16'($urandom_range(255)));
      set_reg(REG_GAP_SAMPLES, 16'($urandom));
      burst = (ph == 1);
      if (ph == 0) squeeze = 1'b1;
      sent = 0;
      while (sent < 30) begin
        if ($urandom_range(7) == 0) begin
          offer_byte(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
          sent++;
        end else begin
          len = $urandom_range(1, 8);
          send_block(len, $urandom_range(3) == 0);
          sent += len;
        end
      end
      drain();
    end
    burst = 1'b0;

    @(negedge clk_i);
    byte_ch.valid <= 1'b0;
    while (exp_left != 0) @(posedge clk_i);
    // Anything that still comes out now is a surplus symbol.
    repeat (40) @(posedge clk_i);

    if (err_count == 0 && exp_left == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: tape_block_cycle_modulator.f
rtl/tbcm_pkg.sv
rtl/tbcm_in_if.sv
rtl/tbcm_out_if.sv
rtl/tbcm_front.sv
rtl/tbcm_queue.sv
rtl/tbcm_back.sv
rtl/tape_block_cycle_modulator.sv
bench/tbcm_cycle_check.sv
bench/tb_tape_block_cycle_modulator.sv
